// ===== hw/rtl/banked_memory_map_decoder_core_defines.svh =====
// Assertion macros used by the memory map decoder checker
`ifndef BANKED_MEMORY_MAP_DECODER_CORE_DEFINES_SVH
`define BANKED_MEMORY_MAP_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define BMMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmmd check failed");

// next-cycle implication
`define BMMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmmd check failed");

// delayed implication
`define BMMD_ASSERT_DLY2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("bmmd check failed");

`endif

// ===== hw/rtl/bmmd_pkg.sv =====
// Types, constants and codes of the banked memory map decoder
`default_nettype none

package bmmd_pkg;

  localparam int unsigned SCREEN_CELLS = 506;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned BANK_MASK_W = 5;
  localparam int unsigned RAM_DEPTH   = 49152;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);
  localparam int unsigned IO_DEPTH    = 4096;
  localparam int unsigned IO_AW       = $clog2(IO_DEPTH);
  localparam int unsigned CHAR_DEPTH  = 4096;
  localparam int unsigned CHAR_AW     = $clog2(CHAR_DEPTH);
  localparam int unsigned BASIC_DEPTH = 8192;
  localparam int unsigned BASIC_AW    = $clog2(BASIC_DEPTH);
  localparam int unsigned KERN_DEPTH  = 8192;
  localparam int unsigned KERN_AW     = $clog2(KERN_DEPTH);

  // operations
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // display events
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CELL   = 2'd1;
  localparam logic [1:0] EV_SCREEN = 2'd2;
  localparam logic [1:0] EV_BORDER = 2'd3;

  // special I/O addresses
  localparam logic [ADDR_W-1:0] ADDR_VCTL     = 16'h9002;
  localparam logic [ADDR_W-1:0] ADDR_VREG5    = 16'h9005;
  localparam logic [ADDR_W-1:0] ADDR_BORDER   = 16'h900F;
  localparam logic [ADDR_W-1:0] ADDR_KBD_ROWS = 16'h9120;
  localparam logic [ADDR_W-1:0] ADDR_KBD_COLS = 16'h9121;
  localparam logic [ADDR_W-1:0] ADDR_CONST_FF = 16'h912F;
  localparam logic [ADDR_W-1:0] ADDR_CONST_FE = 16'h911C;
  localparam logic [ADDR_W-1:0] ADDR_CONST_7E = 16'h911F;

  localparam logic [ADDR_W-1:0] SCREEN_BASE_HI = 16'h1E00;
  localparam logic [ADDR_W-1:0] SCREEN_BASE_LO = 16'h1000;
  localparam logic [ADDR_W-1:0] COLOR_BASE_HI  = 16'h9600;
  localparam logic [ADDR_W-1:0] COLOR_BASE_LO  = 16'h9400;

  // I/O read kinds
  localparam logic [2:0] IOK_MEM = 3'd0;
  localparam logic [2:0] IOK_FF  = 3'd1;
  localparam logic [2:0] IOK_FE  = 3'd2;
  localparam logic [2:0] IOK_7E  = 3'd3;
  localparam logic [2:0] IOK_KBD = 3'd4;

  // ROM select
  localparam logic [1:0] ROM_CHAR  = 2'd0;
  localparam logic [1:0] ROM_BASIC = 2'd1;
  localparam logic [1:0] ROM_KERN  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
    logic [63:0]       pressed_keys;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] display_event;
    logic [8:0] cell_offset;
  } rsp_t;

  typedef struct packed {
    logic       ram_area;
    logic       ram_on;
    logic       rom_area;
    logic [1:0] rom_sel;
    logic       io_area;
    logic [2:0] io_kind;
    logic       vctl;
    logic       border;
    logic       vreg5;
    logic       kbd_latch;
    logic       scr_hit;
    logic       col_hit;
    logic [8:0] cell_idx;
  } dec_t;

  typedef struct packed {
    logic ram_rd;
    logic ram_wr;
    logic io_rd;
    logic io_wr;
  } mem_ctrl_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [1:0] sel;
  } rom_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmmd_dec.sv =====
// Address decoder: region, bank enable, special I/O registers, display windows
`default_nettype none

module bmmd_dec #(
  parameter int unsigned SCREEN_CELLS = bmmd_pkg::SCREEN_CELLS
) (
  input  logic [bmmd_pkg::ADDR_W-1:0]      address,
  input  logic [bmmd_pkg::BANK_MASK_W-1:0] bank_mask,
  input  logic                             video_high_select,
  output bmmd_pkg::dec_t                   dec
);
  import bmmd_pkg::*;

  logic [ADDR_W-1:0] sbase;
  logic [ADDR_W-1:0] cbase;
  logic [ADDR_W:0]   a_ext;
  logic [ADDR_W:0]   s_end;
  logic [ADDR_W:0]   c_end;
  logic [ADDR_W-1:0] s_off;
  logic [ADDR_W-1:0] c_off;

  always_comb begin
    sbase = video_high_select ? SCREEN_BASE_HI : SCREEN_BASE_LO;
    cbase = video_high_select ? COLOR_BASE_HI : COLOR_BASE_LO;
    a_ext = {1'b0, address};
    s_end = {1'b0, sbase} + (ADDR_W+1)'(SCREEN_CELLS);
    c_end = {1'b0, cbase} + (ADDR_W+1)'(SCREEN_CELLS);
    s_off = address - sbase;
    c_off = address - cbase;

    dec = '0;
    dec.ram_area = (address < 16'h8000) || (address[15:13] == 3'b101);
    if (address < 16'h0400) begin
      dec.ram_on = 1'b1;
    end else if (address < 16'h1000) begin
      dec.ram_on = bank_mask[0];
    end else if (address < 16'h2000) begin
      dec.ram_on = 1'b1;
    end else if (address < 16'h4000) begin
      dec.ram_on = bank_mask[1];
    end else if (address < 16'h6000) begin
      dec.ram_on = bank_mask[2];
    end else if (address < 16'h8000) begin
      dec.ram_on = bank_mask[3];
    end else if (address[15:13] == 3'b101) begin
      dec.ram_on = bank_mask[4];
    end else begin
      dec.ram_on = 1'b0;
    end

    dec.io_area = (address[15:12] == 4'h9);
    if (address[15:12] == 4'h8) begin
      dec.rom_area = 1'b1;
      dec.rom_sel  = ROM_CHAR;
    end else if (address[15:13] == 3'b110) begin
      dec.rom_area = 1'b1;
      dec.rom_sel  = ROM_BASIC;
    end else if (address[15:13] == 3'b111) begin
      dec.rom_area = 1'b1;
      dec.rom_sel  = ROM_KERN;
    end else begin
      dec.rom_area = 1'b0;
      dec.rom_sel  = ROM_CHAR;
    end

    case (address)
      ADDR_CONST_FF: dec.io_kind = IOK_FF;
      ADDR_CONST_FE: dec.io_kind = IOK_FE;
      ADDR_CONST_7E: dec.io_kind = IOK_7E;
      ADDR_KBD_COLS: dec.io_kind = IOK_KBD;
      default:       dec.io_kind = IOK_MEM;
    endcase

    dec.vctl      = (address == ADDR_VCTL);
    dec.border    = (address == ADDR_BORDER);
    dec.vreg5     = (address == ADDR_VREG5);
    dec.kbd_latch = (address == ADDR_KBD_ROWS);

    // screen window only counts inside the fixed RAM at 0x1000-0x1FFF
    dec.scr_hit  = (address[15:12] == 4'h1) && (address >= sbase) && (a_ext < s_end);
    dec.col_hit  = dec.io_area && (address >= cbase) && (a_ext < c_end);
    dec.cell_idx = dec.scr_hit ? s_off[8:0] : c_off[8:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmmd_ram.sv =====
// Main RAM and I/O page memories with the post-reset clearing sweep
`default_nettype none

module bmmd_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  bmmd_pkg::mem_ctrl_t         ctrl,
  input  logic [bmmd_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                  wdata,
  output logic [7:0]                  ram_q,
  output logic [7:0]                  io_q,
  output logic                        clearing
);
  import bmmd_pkg::*;

  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_DEPTH - 1);

  logic [7:0] main_ram [0:RAM_DEPTH-1];
  logic [7:0] io_page  [0:IO_DEPTH-1];

  logic [RAM_AW-1:0] clr_addr;
  logic              ram_we;
  logic              io_we;
  logic [RAM_AW-1:0] ram_wa;
  logic [IO_AW-1:0]  io_wa;
  logic [7:0]        wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // the I/O page is swept by the low bits of the same counter
  always_comb begin
    ram_we = clearing || ctrl.ram_wr;
    io_we  = clearing || ctrl.io_wr;
    ram_wa = clearing ? clr_addr : addr[RAM_AW-1:0];
    io_wa  = clearing ? clr_addr[IO_AW-1:0] : addr[IO_AW-1:0];
    wd     = clearing ? 8'h00 : wdata;
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      main_ram[ram_wa] <= wd;
    end
    if (ctrl.ram_rd) begin
      ram_q <= main_ram[addr[RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (io_we) begin
      io_page[io_wa] <= wd;
    end
    if (ctrl.io_rd) begin
      io_q <= io_page[addr[IO_AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmmd_rom.sv =====
// Character, BASIC and kernel ROM memories, loadable one byte at a time
`default_nettype none

module bmmd_rom (
  input  logic                        clk,
  input  bmmd_pkg::rom_ctrl_t         ctrl,
  input  logic [bmmd_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                  wdata,
  output logic [7:0]                  rom_q
);
  import bmmd_pkg::*;

  logic [7:0] chr_mem  [0:CHAR_DEPTH-1];
  logic [7:0] bas_mem  [0:BASIC_DEPTH-1];
  logic [7:0] kern_rom [0:KERN_DEPTH-1];

  logic [7:0] char_q;
  logic [7:0] basic_q;
  logic [7:0] kern_q;
  logic [1:0] sel_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr && (ctrl.sel == ROM_CHAR)) begin
      chr_mem[addr[CHAR_AW-1:0]] <= wdata;
    end
    if (ctrl.rd && (ctrl.sel == ROM_CHAR)) begin
      char_q <= chr_mem[addr[CHAR_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && (ctrl.sel == ROM_BASIC)) begin
      bas_mem[addr[BASIC_AW-1:0]] <= wdata;
    end
    if (ctrl.rd && (ctrl.sel == ROM_BASIC)) begin
      basic_q <= bas_mem[addr[BASIC_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && (ctrl.sel == ROM_KERN)) begin
      kern_rom[addr[KERN_AW-1:0]] <= wdata;
    end
    if (ctrl.rd && (ctrl.sel == ROM_KERN)) begin
      kern_q <= kern_rom[addr[KERN_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      sel_q <= ctrl.sel;
    end
  end

  always_comb begin
    case (sel_q)
      ROM_CHAR:  rom_q = char_q;
      ROM_BASIC: rom_q = basic_q;
      ROM_KERN:  rom_q = kern_q;
      default:   rom_q = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/banked_memory_map_decoder_core.sv =====
// Top level of the banked memory map decoder: access sequencer and result register
//
//  channel  | signals                    | direction | flow
//  ---------+----------------------------+-----------+------------------------------
//  command  | start, busy, cmd           | in        | taken when start && !busy
//  result   | done, rsp                  | out       | done high for one cycle, no stall
//  config   | cfg_valid, cfg_ready, cfg_data | in    | bank_mask write, always ready
//
// Each item passes the accept cycle, which issues the memory reads, and then the EXEC
// state, which decides the result and writes back; done follows in the cycle after
// EXEC, in the same cycle that the next item can be accepted. Writes land before the
// next read is issued, so back-to-back accesses to one byte need no forwarding.
// After reset a clearing sweep zeroes main RAM and the I/O page, one entry per cycle,
// with busy high. Config writes are taken during the sweep.
`default_nettype none

module banked_memory_map_decoder_core #(
  parameter int unsigned SCREEN_CELLS = bmmd_pkg::SCREEN_CELLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bmmd_pkg::cmd_t                   cmd,
  output logic                             done,
  output bmmd_pkg::rsp_t                   rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmmd_pkg::BANK_MASK_W-1:0] cfg_data
);
  import bmmd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                   state;
  logic [BANK_MASK_W-1:0] bank_mask;
  logic                   video_high_select;
  logic [7:0]             kbd_rows;
  cmd_t                   item;
  dec_t                   item_dec;
  dec_t                   in_dec;
  rsp_t                   rsp_next;

  logic              accept;
  logic              clearing;
  logic [ADDR_W-1:0] mem_addr;
  mem_ctrl_t         mem_ctrl;
  rom_ctrl_t         rom_ctrl;
  logic [7:0]        ram_q;
  logic [7:0]        io_q;
  logic [7:0]        rom_q;
  logic [7:0]        kbd_val;
  logic              vhs_wr;

  assign busy      = clearing || (state == ST_EXEC);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  bmmd_dec #(
    .SCREEN_CELLS (SCREEN_CELLS)
  ) u_dec (
    .address           (cmd.address),
    .bank_mask         (bank_mask),
    .video_high_select (video_high_select),
    .dec               (in_dec)
  );

  bmmd_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mem_ctrl),
    .addr     (mem_addr),
    .wdata    (item.write_data),
    .ram_q    (ram_q),
    .io_q     (io_q),
    .clearing (clearing)
  );

  bmmd_rom u_rom (
    .clk   (clk),
    .ctrl  (rom_ctrl),
    .addr  (mem_addr),
    .wdata (item.write_data),
    .rom_q (rom_q)
  );

  // key matrix: a row takes part when its latch bit is low
  always_comb begin
    kbd_val = 8'hFF;
    for (int r = 0; r < 8; r++) begin
      if (!kbd_rows[r]) begin
        kbd_val = kbd_val & ~item.pressed_keys[8*r +: 8];
      end
    end
  end

  always_comb begin
    mem_addr        = (state == ST_EXEC) ? item.address : cmd.address;
    mem_ctrl        = '0;
    mem_ctrl.ram_rd = accept && in_dec.ram_area && in_dec.ram_on;
    mem_ctrl.io_rd  = accept && in_dec.io_area;
    rom_ctrl        = '0;
    rom_ctrl.rd     = accept && in_dec.rom_area;
    rom_ctrl.sel    = (state == ST_EXEC) ? item_dec.rom_sel : in_dec.rom_sel;
    rsp_next        = '0;
    vhs_wr          = 1'b0;

    if (state == ST_EXEC) begin
      case (item.operation)
        OP_READ: begin
          if (item_dec.ram_area) begin
            rsp_next.read_data = item_dec.ram_on ? ram_q : 8'hFF;
          end else if (item_dec.rom_area) begin
            rsp_next.read_data = rom_q;
          end else begin
            case (item_dec.io_kind)
              IOK_FF:  rsp_next.read_data = 8'hFF;
              IOK_FE:  rsp_next.read_data = 8'hFE;
              IOK_7E:  rsp_next.read_data = 8'h7E;
              IOK_KBD: rsp_next.read_data = kbd_val;
              default: rsp_next.read_data = io_q;
            endcase
          end
        end
        OP_WRITE: begin
          if (item_dec.ram_area) begin
            if (item_dec.ram_on) begin
              mem_ctrl.ram_wr = 1'b1;
              if (item_dec.scr_hit) begin
                rsp_next.display_event = EV_CELL;
                rsp_next.cell_offset   = item_dec.cell_idx;
              end
            end
          end else if (item_dec.io_area) begin
            if (item_dec.vctl) begin
              // dropped whole when the high-select bit does not change
              if (io_q[7] != item.write_data[7]) begin
                mem_ctrl.io_wr         = 1'b1;
                vhs_wr                 = 1'b1;
                rsp_next.display_event = EV_SCREEN;
              end
            end else if (io_q != item.write_data) begin
              mem_ctrl.io_wr = 1'b1;
              if (item_dec.border) begin
                rsp_next.display_event = EV_BORDER;
              end else if (item_dec.vreg5) begin
                rsp_next.display_event = EV_SCREEN;
              end else if (item_dec.col_hit) begin
                rsp_next.display_event = EV_CELL;
                rsp_next.cell_offset   = item_dec.cell_idx;
              end
            end
          end
        end
        OP_LOAD: begin
          rom_ctrl.wr = item_dec.rom_area;
        end
        default: begin
          rsp_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      done              <= 1'b0;
      bank_mask         <= '0;
      video_high_select <= 1'b1;
      kbd_rows          <= 8'h00;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bank_mask <= cfg_data;
      end
      done <= (state == ST_EXEC);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (vhs_wr) begin
        video_high_select <= item.write_data[7];
      end
      // shadow of the keyboard row latch byte in the I/O page
      if (mem_ctrl.io_wr && item_dec.kbd_latch) begin
        kbd_rows <= item.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= cmd;
      item_dec <= in_dec;
    end
    if (state == ST_EXEC) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmmd_chk.sv =====
// Port-level checker for the memory map decoder, bound to the top level
`default_nettype none

`include "banked_memory_map_decoder_core_defines.svh"

module bmmd_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input bmmd_pkg::cmd_t cmd,
  input logic           done,
  input bmmd_pkg::rsp_t rsp
);
  import bmmd_pkg::*;

  `BMMD_ASSERT_DLY2(a_done_after_accept, start && !busy, done)
  `BMMD_ASSERT_NXT(a_busy_after_accept, start && !busy, busy && !done)
  `BMMD_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, 2))
  `BMMD_ASSERT_IMP(a_read_data_zero, done && ($past(cmd.operation, 2) != OP_READ), rsp.read_data == 8'h00)
  `BMMD_ASSERT_IMP(a_cell_only_for_cell, done && (rsp.display_event != EV_CELL), rsp.cell_offset == 9'd0)

endmodule

bind banked_memory_map_decoder_core bmmd_chk u_bmmd_chk (.*);

`default_nettype wire
